// ----- rtl/core/tsbw_pkg.sv -----
// Shared types and constants for the tile map scroll blit walker.
// No dependencies; every other file of the block but tsbw_map_mem refers to it by scoped names.
package tsbw_pkg;

   // Parameter defaults
   localparam int MAP_ENTRIES_DEF = 4096;
   localparam int MAX_TILE_DEF    = 64;

   // Field widths
   localparam int SCROLL_W = 16;
   localparam int TILE_W   = 7;   // tile size, map width/height, col, row
   localparam int SCREEN_W = 12;
   localparam int WALK_W   = 13;
   localparam int DEST_W   = 14;
   localparam int INDEX_W  = 12;
   localparam int WORD_W   = 16;
   localparam int NUM_W    = 8;   // tile number
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Serial divider geometry
   localparam int DIVD_W    = 17;
   localparam int DIV_CNT_W = 5;

   // Commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SIZE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPARENT  = 3'd7;

   // Reset values
   localparam logic [TILE_W-1:0]   TILE_SIZE_RST     = 7'd16;
   localparam logic [TILE_W-1:0]   MAP_WIDTH_RST     = 7'd16;
   localparam logic [TILE_W-1:0]   MAP_HEIGHT_RST    = 7'd16;
   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd176;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd220;

   localparam logic [NUM_W-1:0] TILE_SKIP = 8'hFF;

   // Scroll geometry derived from configuration and walk position
   typedef struct packed {
      logic [TILE_W-1:0] sub_x;     // scroll_x mod tile size
      logic [TILE_W-1:0] sub_y;     // scroll_y mod tile size
      logic [TILE_W-1:0] col_home;  // map column at walk_x = 0
      logic [TILE_W-1:0] row_home;  // map row at walk_y = 0
      logic [TILE_W-1:0] col;       // map column at current walk_x
      logic [TILE_W-1:0] row;       // map row at current walk_y
   } geom_type;

endpackage

// ----- rtl/core/tsbw_if.sv -----
// Valid/ready channel interfaces for the walker's request and response sides.
// Depends on tsbw_pkg for field widths.
interface tsbw_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [tsbw_pkg::INDEX_W-1:0]    map_index;
   logic [tsbw_pkg::WORD_W-1:0]     tile_word;

   modport source (output valid, cmd, map_index, tile_word, input ready);
   modport sink   (input valid, cmd, map_index, tile_word, output ready);
endinterface

interface tsbw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [tsbw_pkg::DEST_W-1:0] dest_x;
   logic signed [tsbw_pkg::DEST_W-1:0] dest_y;
   logic [tsbw_pkg::DEST_W-1:0]       source_offset;
   logic                              draw;
   logic                              transparent;
   logic                              last_of_frame;

   modport source (output valid, dest_x, dest_y, source_offset, draw, transparent,
                   last_of_frame, input ready);
   modport sink   (input valid, dest_x, dest_y, source_offset, draw, transparent,
                   last_of_frame, output ready);
endinterface

// ----- rtl/core/tsbw_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on tsbw_pkg for operand widths.
module tsbw_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tsbw_pkg::DIVD_W-1:0]      dividend,
   input  logic [tsbw_pkg::TILE_W-1:0]      divisor,
   output logic                             done,
   output logic [tsbw_pkg::DIVD_W-1:0]      quot,
   output logic [tsbw_pkg::TILE_W-1:0]      rem
);

   localparam int DW = tsbw_pkg::DIVD_W;
   localparam int RW = tsbw_pkg::TILE_W;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [tsbw_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DW-1:0]                     quot_ff, quot_in;
   logic [RW-1:0]                     rem_ff, rem_in;
   logic [RW-1:0]                     dvs_ff, dvs_in;
   logic [RW:0]                       trial;
   logic                              fits;

   assign trial = {rem_ff, quot_ff[DW-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = tsbw_pkg::DIV_CNT_W'(DW);
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? RW'(trial - {1'b0, dvs_ff}) : trial[RW-1:0];
         quot_in = {quot_ff[DW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == tsbw_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/core/tsbw_seq.sv -----
// Geometry sequencer: after reset or a register write it rebuilds the scroll
// remainders and wrapped map row/column with eight passes of tsbw_div.
module tsbw_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             kick,
   input  logic [tsbw_pkg::SCROLL_W-1:0]    scroll_x,
   input  logic [tsbw_pkg::SCROLL_W-1:0]    scroll_y,
   input  logic [tsbw_pkg::WALK_W-1:0]      walk_x,
   input  logic [tsbw_pkg::WALK_W-1:0]      walk_y,
   input  logic [tsbw_pkg::TILE_W-1:0]      ts,
   input  logic [tsbw_pkg::TILE_W-1:0]      w,
   input  logic [tsbw_pkg::TILE_W-1:0]      h,
   output tsbw_pkg::geom_type               geo,
   output logic                             busy,
   output logic                             load
);

   localparam int DW = tsbw_pkg::DIVD_W;

   localparam logic [2:0] OP_SX_DIV   = 3'd0;
   localparam logic [2:0] OP_CH_MOD   = 3'd1;
   localparam logic [2:0] OP_WX_DIV   = 3'd2;
   localparam logic [2:0] OP_COL_MOD  = 3'd3;
   localparam logic [2:0] OP_SY_DIV   = 3'd4;
   localparam logic [2:0] OP_RH_MOD   = 3'd5;
   localparam logic [2:0] OP_WY_DIV   = 3'd6;
   localparam logic [2:0] OP_ROW_MOD  = 3'd7;

   logic                          run_ff, run_in;
   logic                          issued_ff, issued_in;
   logic                          load_ff, load_in;
   logic [2:0]                    op_ff, op_in;
   logic [DW-1:0]                 tmp_ff, tmp_in;
   tsbw_pkg::geom_type            geo_ff, geo_in;

   logic                          div_start, div_done;
   logic [DW-1:0]                 div_dividend, div_quot;
   logic [tsbw_pkg::TILE_W-1:0]   div_divisor, div_rem;

   tsbw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      case (op_ff)
         OP_SX_DIV: begin
            div_dividend = DW'(scroll_x);
            div_divisor  = ts;
         end
         OP_WX_DIV: begin
            div_dividend = DW'(scroll_x) + DW'(walk_x);
            div_divisor  = ts;
         end
         OP_SY_DIV: begin
            div_dividend = DW'(scroll_y);
            div_divisor  = ts;
         end
         OP_WY_DIV: begin
            div_dividend = DW'(scroll_y) + DW'(walk_y);
            div_divisor  = ts;
         end
         OP_CH_MOD, OP_COL_MOD: begin
            div_dividend = tmp_ff;
            div_divisor  = w;
         end
         default: begin
            div_dividend = tmp_ff;
            div_divisor  = h;
         end
      endcase
   end

   assign div_start = run_ff && !issued_ff && !kick;

   always_comb begin
      run_in    = run_ff;
      issued_in = issued_ff;
      load_in   = 1'b0;
      op_in     = op_ff;
      tmp_in    = tmp_ff;
      geo_in    = geo_ff;
      if (kick) begin
         run_in    = 1'b1;
         issued_in = 1'b0;
         op_in     = OP_SX_DIV;
      end else if (div_start) begin
         issued_in = 1'b1;
      end else if (run_ff && div_done) begin
         tmp_in    = div_quot;
         issued_in = 1'b0;
         op_in     = op_ff + 3'd1;
         case (op_ff)
            OP_SX_DIV:  geo_in.sub_x    = div_rem;
            OP_CH_MOD:  geo_in.col_home = div_rem;
            OP_COL_MOD: geo_in.col      = div_rem;
            OP_SY_DIV:  geo_in.sub_y    = div_rem;
            OP_RH_MOD:  geo_in.row_home = div_rem;
            OP_ROW_MOD: geo_in.row      = div_rem;
            default:    ;
         endcase
         if (op_ff == OP_ROW_MOD) begin
            run_in  = 1'b0;
            load_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b1;
         issued_ff <= 1'b0;
         load_ff   <= 1'b0;
         op_ff     <= OP_SX_DIV;
      end else begin
         run_ff    <= run_in;
         issued_ff <= issued_in;
         load_ff   <= load_in;
         op_ff     <= op_in;
      end
      tmp_ff <= tmp_in;
      geo_ff <= geo_in;
   end

   assign geo  = geo_ff;
   assign busy = run_ff || load_ff;
   assign load = load_ff;

endmodule

// ----- rtl/core/tsbw_map_mem.sv -----
// Tile map store: one write port, one registered read port, 8-bit entries.
// Depends on nothing but its parameter.
module tsbw_map_mem #(
   parameter  int ENTRIES = 4096,
   localparam int AW      = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [ENTRIES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tilemap_scroll_blit_walker.sv -----
// Top level of the tile map scroll blit walker: registers, walk state, map store
// and result stage. Depends on tsbw_pkg, tsbw_if, tsbw_seq, tsbw_map_mem.
//
//   port     dir   flow        carries
//   req_ch   in    valid/ready cmd, map_index, tile_word
//   rsp_ch   out   valid/ready dest_x, dest_y, source_offset, draw, transparent,
//                              last_of_frame
//   csr_*    in    write only  register index and data, taken when csr_we is high
//
// A step transfer reads the map store at the accept edge and its result is
// registered in the cycle after; no new request is taken while that map read is
// in flight. After reset and after every register write the geometry sequencer
// runs eight serial divisions and a final load with req_ch.ready low. A stalled
// result holds in the output register; the next step is taken in the cycle the
// result transfers.
module tilemap_scroll_blit_walker #(
   parameter int MAP_ENTRIES = tsbw_pkg::MAP_ENTRIES_DEF,
   parameter int MAX_TILE    = tsbw_pkg::MAX_TILE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   tsbw_req_if.sink                            req_ch,
   tsbw_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [tsbw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tsbw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW  = $clog2(MAP_ENTRIES);
   localparam int SW  = (AW > tsbw_pkg::DEST_W) ? AW : tsbw_pkg::DEST_W;
   localparam int IW  = (AW > tsbw_pkg::INDEX_W) ? AW : tsbw_pkg::INDEX_W;
   localparam int TW  = tsbw_pkg::TILE_W;
   localparam int DW  = tsbw_pkg::DEST_W;
   localparam int WW  = tsbw_pkg::WALK_W;

   // configuration
   logic [tsbw_pkg::SCROLL_W-1:0] scroll_x_ff, scroll_y_ff;
   logic [TW-1:0]                 tile_size_ff, map_width_ff, map_height_ff;
   logic [tsbw_pkg::SCREEN_W-1:0] screen_width_ff, screen_height_ff;
   logic                          transparent_ff;

   // walk state
   logic [WW-1:0] walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic [TW-1:0] col_ff, col_in, row_ff, row_in;

   // step in flight and result stage
   logic                 pend_ff;
   logic [DW-1:0]        p_dest_x_ff, p_dest_y_ff;
   logic                 p_last_ff, p_trans_ff;
   logic [TW-1:0]        p_ts_ff;
   logic                 rsp_valid_ff;
   logic [DW-1:0]        o_dest_x_ff, o_dest_y_ff, o_source_ff;
   logic                 o_draw_ff, o_trans_ff, o_last_ff;

   logic [TW-1:0]        ts, w_eff, h_eff;
   logic                 req_ready, req_fire, step_fire, wr_fire, last_pos;
   logic [DW-1:0]        row_base, dest_x_now, dest_y_now;
   logic [SW-1:0]        map_sum;
   logic [IW-1:0]        wr_index;
   logic [7:0]           rd_data;
   logic [TW+7:0]        prod;
   logic                 draw_now;
   logic                 seq_busy, seq_load;
   tsbw_pkg::geom_type   geo;

   // effective tile size and wrap moduli
   always_comb begin
      if (tile_size_ff == '0) begin
         ts = TW'(1);
      end else if ({2'b00, tile_size_ff} > 9'(MAX_TILE)) begin
         ts = TW'(MAX_TILE);
      end else begin
         ts = tile_size_ff;
      end
   end
   assign w_eff = (map_width_ff == '0) ? TW'(1) : map_width_ff;
   assign h_eff = (map_height_ff == '0) ? TW'(1) : map_height_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff      <= '0;
         scroll_y_ff      <= '0;
         tile_size_ff     <= tsbw_pkg::TILE_SIZE_RST;
         map_width_ff     <= tsbw_pkg::MAP_WIDTH_RST;
         map_height_ff    <= tsbw_pkg::MAP_HEIGHT_RST;
         screen_width_ff  <= tsbw_pkg::SCREEN_WIDTH_RST;
         screen_height_ff <= tsbw_pkg::SCREEN_HEIGHT_RST;
         transparent_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            tsbw_pkg::CSR_SCROLL_X:      scroll_x_ff      <= csr_wdata;
            tsbw_pkg::CSR_SCROLL_Y:      scroll_y_ff      <= csr_wdata;
            tsbw_pkg::CSR_TILE_SIZE:     tile_size_ff     <= csr_wdata[TW-1:0];
            tsbw_pkg::CSR_MAP_WIDTH:     map_width_ff     <= csr_wdata[TW-1:0];
            tsbw_pkg::CSR_MAP_HEIGHT:    map_height_ff    <= csr_wdata[TW-1:0];
            tsbw_pkg::CSR_SCREEN_WIDTH:
               screen_width_ff  <= csr_wdata[tsbw_pkg::SCREEN_W-1:0];
            tsbw_pkg::CSR_SCREEN_HEIGHT:
               screen_height_ff <= csr_wdata[tsbw_pkg::SCREEN_W-1:0];
            tsbw_pkg::CSR_TRANSPARENT:   transparent_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   tsbw_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .kick     (csr_we),
      .scroll_x (scroll_x_ff),
      .scroll_y (scroll_y_ff),
      .walk_x   (walk_x_ff),
      .walk_y   (walk_y_ff),
      .ts       (ts),
      .w        (w_eff),
      .h        (h_eff),
      .geo      (geo),
      .busy     (seq_busy),
      .load     (seq_load)
   );

   // handshake
   assign req_ready = !seq_busy && !pend_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire  = req_ch.valid && req_ready;
   assign step_fire = req_fire && (req_ch.cmd == tsbw_pkg::CMD_STEP);
   assign wr_fire   = req_fire && (req_ch.cmd == tsbw_pkg::CMD_WRITE);

   // map address of the current position
   assign row_base = DW'({7'b0, row_ff} * {7'b0, w_eff});
   assign map_sum  = SW'(row_base) + SW'(col_ff);
   assign wr_index = IW'(req_ch.map_index);

   tsbw_map_mem #(.ENTRIES(MAP_ENTRIES)) u_map (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_index[AW-1:0]),
      .wr_data (req_ch.tile_word[7:0]),
      .rd_en   (step_fire),
      .rd_addr (map_sum[AW-1:0]),
      .rd_data (rd_data)
   );

   assign dest_x_now = DW'({1'b0, walk_x_ff}) - DW'(geo.sub_x);
   assign dest_y_now = DW'({1'b0, walk_y_ff}) - DW'(geo.sub_y);

   // walk advance; column and row follow the walk one tile at a time
   always_comb begin
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      last_pos  = 1'b0;
      if (seq_load) begin
         col_in = geo.col;
         row_in = geo.row;
      end else if (step_fire) begin
         if (walk_x_ff < {1'b0, screen_width_ff}) begin
            walk_x_in = walk_x_ff + WW'(ts);
            col_in    = (col_ff == w_eff - 1'b1) ? '0 : col_ff + 1'b1;
         end else if (walk_y_ff < {1'b0, screen_height_ff}) begin
            walk_y_in = walk_y_ff + WW'(ts);
            walk_x_in = '0;
            col_in    = geo.col_home;
            row_in    = (row_ff == h_eff - 1'b1) ? '0 : row_ff + 1'b1;
         end else begin
            last_pos  = 1'b1;
            walk_x_in = '0;
            walk_y_in = '0;
            col_in    = geo.col_home;
            row_in    = geo.row_home;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff <= '0;
         walk_y_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // step in flight while the map read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= step_fire;
      end
      if (step_fire) begin
         p_dest_x_ff <= dest_x_now;
         p_dest_y_ff <= dest_y_now;
         p_last_ff   <= last_pos;
         p_ts_ff     <= ts;
         p_trans_ff  <= transparent_ff;
      end
   end

   assign prod     = (TW + 8)'(p_ts_ff) * (TW + 8)'(rd_data);
   assign draw_now = (rd_data != tsbw_pkg::TILE_SKIP);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (pend_ff) begin
         o_dest_x_ff <= p_dest_x_ff;
         o_dest_y_ff <= p_dest_y_ff;
         o_source_ff <= draw_now ? prod[DW-1:0] : '0;
         o_draw_ff   <= draw_now;
         o_trans_ff  <= p_trans_ff;
         o_last_ff   <= p_last_ff;
      end
   end

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.dest_x        = o_dest_x_ff;
   assign rsp_ch.dest_y        = o_dest_y_ff;
   assign rsp_ch.source_offset = o_source_ff;
   assign rsp_ch.draw          = o_draw_ff;
   assign rsp_ch.transparent   = o_trans_ff;
   assign rsp_ch.last_of_frame = o_last_ff;

   // incremental column/row stay inside the wrap moduli once geometry is settled
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      !seq_busy |-> (col_ff < w_eff) && (row_ff < h_eff))
      else $error("map column or row outside wrap range");

   a_step_pend: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> pend_ff)
      else $error("accepted step has no map read in flight");

   a_pend_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_valid_ff)
      else $error("map read did not land in result register");

   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> seq_busy && !req_ready)
      else $error("register write did not restart geometry sequencer");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      step_fire && last_pos |=> (walk_x_ff == '0) && (walk_y_ff == '0))
      else $error("walk did not restart after last position");

endmodule

// ----- test/tb_tilemap_scroll_blit_walker.sv -----
// Testbench for tilemap_scroll_blit_walker: directed and random map writes and walk steps,
// checked against an in-bench predictor of the scrolled, wrapping tile walk.
// Depends on tsbw_pkg, tsbw_if and the walker RTL.
module tb_tilemap_scroll_blit_walker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RUN_LIMIT    = 1_000_000;
   localparam int unsigned RANDOM_ITEMS = 1600;
   localparam int unsigned MAP_DEPTH    = tsbw_pkg::MAP_ENTRIES_DEF;
   localparam int unsigned MAX_TILE     = tsbw_pkg::MAX_TILE_DEF;
   localparam int unsigned DRAIN_CYCLES = 6;

   localparam int DEST_W     = tsbw_pkg::DEST_W;
   localparam int SCROLL_W   = tsbw_pkg::SCROLL_W;
   localparam int TILE_W     = tsbw_pkg::TILE_W;
   localparam int SCREEN_W   = tsbw_pkg::SCREEN_W;
   localparam int WALK_W     = tsbw_pkg::WALK_W;
   localparam int NUM_W      = tsbw_pkg::NUM_W;
   localparam int INDEX_W    = tsbw_pkg::INDEX_W;
   localparam int WORD_W     = tsbw_pkg::WORD_W;
   localparam int CSR_IDX_W  = tsbw_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = tsbw_pkg::CSR_DATA_W;

   typedef enum {FLOW_FREE, FLOW_CHOPPY, FLOW_BLOCKED} flow_type;

   typedef struct packed {
      logic signed [DEST_W-1:0] dest_x;
      logic signed [DEST_W-1:0] dest_y;
      logic [DEST_W-1:0]        source_offset;
      logic                     draw;
      logic                     transparent;
      logic                     last_of_frame;
   } blit_type;

   typedef struct packed {
      logic [SCROLL_W-1:0] scroll_x;
      logic [SCROLL_W-1:0] scroll_y;
      logic [TILE_W-1:0]   tile_size;
      logic [TILE_W-1:0]   map_width;
      logic [TILE_W-1:0]   map_height;
      logic [SCREEN_W-1:0] screen_width;
      logic [SCREEN_W-1:0] screen_height;
      logic                transparent_mode;
   } walker_regs_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tsbw_req_if req_ch();
   tsbw_rsp_if rsp_ch();

   tilemap_scroll_blit_walker dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   walker_regs_type       regs;
   logic [WALK_W-1:0]     walk_x, walk_y;
   logic [NUM_W-1:0]      tile_mem [MAP_DEPTH];
   bit                    map_written [MAP_DEPTH];
   blit_type              pending_blits [$];

   // traffic shaping
   flow_type              rsp_flow  = FLOW_CHOPPY;
   int unsigned           gap_max   = 3;
   int unsigned           burst_max = 4;
   int unsigned           burst_left = 0;
   int unsigned           stall_left = 0;
   int unsigned           items_sent = 0;
   int unsigned           mismatches = 0;

   function automatic int unsigned eff_tile(input logic [TILE_W-1:0] t);
      if (t == '0) return 1;
      if (t > MAX_TILE) return MAX_TILE;
      return t;
   endfunction

   function automatic int unsigned eff_extent(input logic [TILE_W-1:0] v);
      return (v == '0) ? 1 : v;
   endfunction

   // map entry that the next step reads
   function automatic int unsigned next_addr();
      int unsigned ts, w, h, col, row;
      ts  = eff_tile(regs.tile_size);
      w   = eff_extent(regs.map_width);
      h   = eff_extent(regs.map_height);
      row = ((32'(walk_y) + 32'(regs.scroll_y)) / ts) % h;
      col = ((32'(walk_x) + 32'(regs.scroll_x)) / ts) % w;
      return (col + row * w) % MAP_DEPTH;
   endfunction

   task automatic predict_blit(output blit_type b);
      int unsigned      ts, addr;
      logic [NUM_W-1:0] num;
      ts   = eff_tile(regs.tile_size);
      addr = next_addr();
      num  = tile_mem[addr];
      b.dest_x        = DEST_W'(32'(walk_x) - (32'(regs.scroll_x) % ts));
      b.dest_y        = DEST_W'(32'(walk_y) - (32'(regs.scroll_y) % ts));
      b.draw          = (num != tsbw_pkg::TILE_SKIP);
      b.source_offset = b.draw ? DEST_W'(ts * num) : '0;
      b.transparent   = regs.transparent_mode;
      b.last_of_frame = 1'b0;
      if (walk_x < regs.screen_width) begin
         walk_x = WALK_W'(32'(walk_x) + ts);
      end else if (walk_y < regs.screen_height) begin
         walk_y = WALK_W'(32'(walk_y) + ts);
         walk_x = '0;
      end else begin
         b.last_of_frame = 1'b1;
         walk_x = '0;
         walk_y = '0;
      end
   endtask

   // Called right after a rising edge; returns at the edge of the transfer.
   task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input logic [WORD_W-1:0] word);
      blit_type b;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd;
      req_ch.map_index <= idx;
      req_ch.tile_word <= word;
      do @(posedge clock); while (!req_ch.ready);
      if (cmd == tsbw_pkg::CMD_STEP) begin
         predict_blit(b);
         pending_blits.push_back(b);
      end else begin
         tile_mem[idx]    = word[NUM_W-1:0];
         map_written[idx] = 1'b1;
      end
      items_sent++;
   endtask

   // a step never reads an entry that was never written: fill it first
   task automatic send_step();
      int unsigned addr;
      addr = next_addr();
      if (!map_written[addr])
         send_item(tsbw_pkg::CMD_WRITE, INDEX_W'(addr), WORD_W'($urandom_range(0, 65535)));
      send_item(tsbw_pkg::CMD_STEP, INDEX_W'($urandom_range(0, 4095)),
                WORD_W'($urandom_range(0, 65535)));
   endtask

   task automatic settle_block();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_blits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input walker_regs_type c);
      put_reg(tsbw_pkg::CSR_SCROLL_X, c.scroll_x);
      put_reg(tsbw_pkg::CSR_SCROLL_Y, c.scroll_y);
      put_reg(tsbw_pkg::CSR_TILE_SIZE, CSR_DATA_W'(c.tile_size));
      put_reg(tsbw_pkg::CSR_MAP_WIDTH, CSR_DATA_W'(c.map_width));
      put_reg(tsbw_pkg::CSR_MAP_HEIGHT, CSR_DATA_W'(c.map_height));
      put_reg(tsbw_pkg::CSR_SCREEN_WIDTH, CSR_DATA_W'(c.screen_width));
      put_reg(tsbw_pkg::CSR_SCREEN_HEIGHT, CSR_DATA_W'(c.screen_height));
      put_reg(tsbw_pkg::CSR_TRANSPARENT, CSR_DATA_W'(c.transparent_mode));
      csr_we <= 1'b0;
      regs = c;
   endtask

   function automatic logic [TILE_W-1:0] pick_extent();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return TILE_W'(1);
         3: return TILE_W'(MAX_TILE);
         default: return TILE_W'($urandom_range(1, MAX_TILE));
      endcase
   endfunction

   function automatic logic [SCROLL_W-1:0] pick_scroll();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return SCROLL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // mostly a few tiles across, so frames close often
   function automatic logic [SCREEN_W-1:0] pick_screen(input int unsigned ts);
      case ($urandom_range(0, 11))
         0: return '0;
         1: return '1;
         default: return SCREEN_W'(ts * $urandom_range(0, 4) + $urandom_range(0, ts - 1));
      endcase
   endfunction

   // default registers: skip tile, tile number zero, largest tile number
   task automatic test_map_writes_and_skip();
      rsp_flow = FLOW_CHOPPY;
      send_item(tsbw_pkg::CMD_WRITE, 12'd0, 16'hFFFF);
      send_step();
      send_item(tsbw_pkg::CMD_WRITE, 12'd1, 16'h1234);
      send_step();
      send_item(tsbw_pkg::CMD_WRITE, 12'hFFF, 16'h0000);
      send_item(tsbw_pkg::CMD_WRITE, 12'd2, 16'hAB00);
      send_step();
      send_item(tsbw_pkg::CMD_WRITE, 12'd3, 16'h00FE);
      send_step();
   endtask

   // tile size and map extents of zero, zero screen width, then zero screen height
   task automatic test_degenerate_geometry();
      settle_block();
      rsp_flow = FLOW_BLOCKED;
      program_regs('{scroll_x: 16'd5, scroll_y: 16'd3, tile_size: '0, map_width: '0,
                     map_height: '0, screen_width: '0, screen_height: 12'd2,
                     transparent_mode: 1'b1});
      repeat (4) send_step();
      settle_block();
      program_regs('{scroll_x: 16'd5, scroll_y: 16'd3, tile_size: '0, map_width: '0,
                     map_height: '0, screen_width: 12'd2, screen_height: '0,
                     transparent_mode: 1'b1});
      repeat (4) send_step();
   endtask

   // oversized tile and map: address wraps past the store, corners go negative
   task automatic test_wrapped_address();
      settle_block();
      rsp_flow = FLOW_FREE;
      program_regs('{scroll_x: '1, scroll_y: 16'd8127, tile_size: '1, map_width: '1,
                     map_height: '1, screen_width: '1, screen_height: '1,
                     transparent_mode: 1'b0});
      repeat (4) send_step();
   endtask

   task automatic test_random_walks(input int unsigned count);
      walker_regs_type c;
      int unsigned     goal, phase_end, area;
      goal = items_sent + count;
      while (items_sent < goal) begin
         c.scroll_x         = pick_scroll();
         c.scroll_y         = pick_scroll();
         c.tile_size        = pick_extent();
         c.map_width        = pick_extent();
         c.map_height       = pick_extent();
         c.screen_width     = pick_screen(eff_tile(c.tile_size));
         c.screen_height    = pick_screen(eff_tile(c.tile_size));
         c.transparent_mode = 1'($urandom_range(0, 1));
         settle_block();
         program_regs(c);
         case ($urandom_range(0, 2))
            0: begin
               rsp_flow  = FLOW_FREE;
               gap_max   = 1;
               burst_max = 2000;
            end
            1: begin
               rsp_flow  = FLOW_CHOPPY;
               gap_max   = 4;
               burst_max = 6;
            end
            default: begin
               rsp_flow  = FLOW_BLOCKED;
               gap_max   = 12;
               burst_max = 3;
            end
         endcase
         area = eff_extent(c.map_width) * eff_extent(c.map_height);
         if (area > MAP_DEPTH) area = MAP_DEPTH;
         phase_end = items_sent + $urandom_range(20, 120);
         while (items_sent < phase_end && items_sent < goal) begin
            if ($urandom_range(0, 9) < 7) begin
               send_step();
            end else begin
               send_item(tsbw_pkg::CMD_WRITE,
                         INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, area - 1)
                                                        : $urandom_range(0, 4095)),
                         ($urandom_range(0, 4) == 0)
                            ? {8'($urandom_range(0, 255)), tsbw_pkg::TILE_SKIP}
                            : WORD_W'($urandom_range(0, 65535)));
            end
         end
      end
   endtask

   // response side: stall pattern and result check
   always @(posedge clock) begin : result_check
      blit_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{dest_x: rsp_ch.dest_x, dest_y: rsp_ch.dest_y,
                 source_offset: rsp_ch.source_offset, draw: rsp_ch.draw,
                 transparent: rsp_ch.transparent, last_of_frame: rsp_ch.last_of_frame};
         if (pending_blits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected blit: dx=%0d dy=%0d src=%0d draw=%0b tr=%0b last=%0b",
                        got.dest_x, got.dest_y, got.source_offset, got.draw,
                        got.transparent, got.last_of_frame);
         end else begin
            want = pending_blits.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("blit mismatch: expected dx=%0d dy=%0d src=%0d draw=%0b tr=%0b ",
                           want.dest_x, want.dest_y, want.source_offset, want.draw,
                           want.transparent,
                           "last=%0b, got dx=%0d dy=%0d src=%0d draw=%0b tr=%0b last=%0b",
                           want.last_of_frame, got.dest_x, got.dest_y,
                           got.source_offset, got.draw, got.transparent, got.last_of_frame);
            end
         end
      end
      case (rsp_flow)
         FLOW_FREE:   rsp_ch.ready <= 1'b1;
         FLOW_CHOPPY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left != 0) begin
               stall_left--;
               rsp_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 15);
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      endcase
   end

   initial begin : watchdog
      int unsigned cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.cmd       <= tsbw_pkg::CMD_WRITE;
      req_ch.map_index <= '0;
      req_ch.tile_word <= '0;

      regs = '{scroll_x: '0, scroll_y: '0, tile_size: tsbw_pkg::TILE_SIZE_RST,
               map_width: tsbw_pkg::MAP_WIDTH_RST, map_height: tsbw_pkg::MAP_HEIGHT_RST,
               screen_width: tsbw_pkg::SCREEN_WIDTH_RST,
               screen_height: tsbw_pkg::SCREEN_HEIGHT_RST,
               transparent_mode: 1'b0};
      walk_x = '0;
      walk_y = '0;
      foreach (map_written[i]) map_written[i] = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_map_writes_and_skip();
      test_degenerate_geometry();
      test_wrapped_address();
      test_random_walks(RANDOM_ITEMS);

      settle_block();
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
